FILE: sv/bprs_pkg.sv
// Package for the block peak/RMS summarizer: widths, reset values, register
// indexes, controller states and the command/status structs.
// Depends on nothing; every other file of the block uses it.
package bprs_pkg;

   // Fixed field and register widths.
   localparam int RESULT_W        = 16;
   localparam int BLOCK_FRAMES_W  = 13;
   localparam int CHANNEL_COUNT_W = 4;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 13;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_BLOCK    = 4096;
   localparam int DEF_MAX_CHANNELS = 8;
   localparam int DEF_SAMPLE_BITS  = 16;

   // Smallest block length that the block honors.
   localparam int MIN_BLOCK = 128;

   localparam logic [BLOCK_FRAMES_W-1:0]  BLOCK_FRAMES_RESET  = 13'd512;
   localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLOCK_FRAMES  = 2'd0,
      CSR_CHANNEL_COUNT = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_FOLD,
      ST_DIVIDE,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic fold;
      logic div_step;
      logic root_load;
      logic root_step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic accept;
      logic close;
      logic out_free;
   } dp_status_type;

   // Bits of the per-block sample counter.
   function automatic int samples_width(int max_block, int max_channels);
      return $clog2(max_block * max_channels + 1);
   endfunction

   // Bits of the square-sum accumulator, capped at 64; the sum itself saturates.
   function automatic int sum_width(int sample_bits, int max_block, int max_channels);
      int full_w;
      full_w = 2 * (sample_bits - 1) + samples_width(max_block, max_channels);
      return (full_w > 64) ? 64 : full_w;
   endfunction

endpackage

FILE: sv/bprs_sample_if.sv
// Input channel of the summarizer: one audio sample per beat.
// Depends on bprs_pkg for the default sample width.
interface bprs_sample_if #(
   parameter int SAMPLE_BITS = bprs_pkg::DEF_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          end_of_stream;

   modport source (output valid, output sample, output end_of_stream, input ready);
   modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

FILE: sv/bprs_summary_if.sv
// Result channel of the summarizer: one block summary per beat.
// Depends on bprs_pkg for the result width.
interface bprs_summary_if;
   import bprs_pkg::*;

   logic                valid;
   logic                ready;
   logic [RESULT_W-1:0] peak;
   logic [RESULT_W-1:0] rms;
   logic                last_block;

   modport source (output valid, output peak, output rms, output last_block, input ready);
   modport sink   (input valid, input peak, input rms, input last_block, output ready);
endinterface

FILE: sv/block_peak_rms_summarizer.sv
// Top level of the block peak/RMS summarizer: controller plus datapath.
// Depends on bprs_pkg, bprs_sample_if, bprs_summary_if, bprs_ctrl, bprs_datapath.
//
//   Port      Direction  Beat contents
//   req_chan  in         sample (signed, SAMPLE_BITS), end_of_stream
//   rsp_chan  out        peak, rms (16 bits unsigned), last_block
//   csr_*     in         write enable, register index, 13-bit write data
//
// Samples that do not close a block stream in at one per cycle. After a
// closing sample req_chan.ready stays low through one fold, SUM_W restoring
// divide steps (46 at the default parameters), one root load, SAMPLE_BITS
// square root steps and one result load.
// The result load waits while the previous summary is still unaccepted.
// Reset is synchronous and active high; it clears the accumulators and counters
// and restores block_frames to 512 and channel_count to 2.
// The summary sits in an output register, so accumulation of the next
// block resumes while rsp_chan stalls.
module block_peak_rms_summarizer #(
   parameter int MAX_BLOCK    = bprs_pkg::DEF_MAX_BLOCK,
   parameter int MAX_CHANNELS = bprs_pkg::DEF_MAX_CHANNELS,
   parameter int SAMPLE_BITS  = bprs_pkg::DEF_SAMPLE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [bprs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bprs_pkg::CSR_DATA_W-1:0]  csr_write_data,
   bprs_sample_if.sink                      req_chan,
   bprs_summary_if.source                   rsp_chan
);
   import bprs_pkg::*;

   // The divider runs one step per accumulator bit, the root one per result bit.
   localparam int DIV_STEPS  = sum_width(SAMPLE_BITS, MAX_BLOCK, MAX_CHANNELS);
   localparam int ROOT_STEPS = SAMPLE_BITS;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   bprs_ctrl #(
      .DIV_STEPS  (DIV_STEPS),
      .ROOT_STEPS (ROOT_STEPS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   bprs_datapath #(
      .MAX_BLOCK    (MAX_BLOCK),
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .cmd            (cmd),
      .status         (status)
   );
endmodule

FILE: sv/bprs_ctrl.sv
// Controller of the summarizer: state machine and step counter that
// sequence accumulate, divide, square root and result load.
// Depends on bprs_pkg.
module bprs_ctrl #(
   parameter int DIV_STEPS  = 46,
   parameter int ROOT_STEPS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bprs_pkg::dp_status_type status,
   output bprs_pkg::ctrl_cmd_type  cmd
);
   import bprs_pkg::*;

   localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               div_last, root_last;

   assign div_last  = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign root_last = (step_ff == STEP_W'(ROOT_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (status.accept && status.close) state_in = ST_FOLD;
         end
         ST_FOLD:      state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_last) state_in = ST_ROOT_LOAD;
         end
         ST_ROOT_LOAD: state_in = ST_ROOT;
         ST_ROOT: begin
            if (root_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_ACCUM;
         end
         default:      state_in = ST_ACCUM;
      endcase
   end

   always_comb begin
      step_in = '0;
      if ((state_ff == ST_DIVIDE && !div_last) || (state_ff == ST_ROOT && !root_last)) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_ACCUM:     cmd.req_ready = 1'b1;
         ST_FOLD:      cmd.fold      = 1'b1;
         ST_DIVIDE:    cmd.div_step  = 1'b1;
         ST_ROOT_LOAD: cmd.root_load = 1'b1;
         ST_ROOT:      cmd.root_step = 1'b1;
         ST_EMIT:      cmd.emit      = status.out_free;
         default:      cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // A closing beat always leads straight into the fold cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM && status.accept && status.close) |=> state_ff == ST_FOLD)
      else $error("closing beat did not start a fold");

   // The step counter only runs inside the divide and root phases.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM || state_ff == ST_EMIT) |-> step_ff == '0)
      else $error("step counter not idle outside iteration");

   // Input is never taken while a block summary is being worked out.
   assert property (@(posedge clock) disable iff (reset)
      cmd.req_ready |-> !(cmd.fold || cmd.div_step || cmd.root_step || cmd.emit))
      else $error("input ready during summary computation");
endmodule

FILE: sv/bprs_datapath.sv
// Datapath of the summarizer: configuration registers, frame counters,
// peak and square-sum accumulators, serial divider, serial square root
// and the result register. Depends on bprs_pkg and both channel interfaces.
module bprs_datapath #(
   parameter int MAX_BLOCK    = bprs_pkg::DEF_MAX_BLOCK,
   parameter int MAX_CHANNELS = bprs_pkg::DEF_MAX_CHANNELS,
   parameter int SAMPLE_BITS  = bprs_pkg::DEF_SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [bprs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bprs_pkg::CSR_DATA_W-1:0]   csr_write_data,
   bprs_sample_if.sink                       req_chan,
   bprs_summary_if.source                    rsp_chan,
   input  bprs_pkg::ctrl_cmd_type            cmd,
   output bprs_pkg::dp_status_type           status
);
   import bprs_pkg::*;

   localparam int FRAMES_W  = $clog2(MAX_BLOCK + 1);
   localparam int BF_CMP_W  = (FRAMES_W > BLOCK_FRAMES_W) ? FRAMES_W : BLOCK_FRAMES_W;
   localparam int CC_NEED_W = $clog2(MAX_CHANNELS + 1);
   localparam int CC_CMP_W  = (CC_NEED_W > CHANNEL_COUNT_W) ? CC_NEED_W : CHANNEL_COUNT_W;
   localparam int CHAN_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int SAMPLES_W = samples_width(MAX_BLOCK, MAX_CHANNELS);
   localparam int SUM_W     = sum_width(SAMPLE_BITS, MAX_BLOCK, MAX_CHANNELS);
   localparam int SQ_W      = 2 * SAMPLE_BITS - 1;
   localparam int MEAN_W    = 2 * SAMPLE_BITS - 1;
   localparam int ROOT_W    = SAMPLE_BITS;
   localparam int RAD_W     = 2 * ROOT_W;

   // Configuration.
   logic [BLOCK_FRAMES_W-1:0]  block_frames_ff;
   logic [CHANNEL_COUNT_W-1:0] channel_count_ff;
   logic [BF_CMP_W-1:0]        bf_wide, bf_eff;
   logic [CC_CMP_W-1:0]        cc_wide, cc_eff;
   logic [FRAMES_W-1:0]        frame_limit;

   // Accumulation.
   logic                       accept;
   logic [SAMPLE_BITS-1:0]     mag;
   logic [2*SAMPLE_BITS-1:0]   mag_sq;
   logic [CHAN_W-1:0]          chan_pos_ff, chan_pos_in;
   logic [FRAMES_W-1:0]        frames_ff, frames_in, frame_next;
   logic                       chan_last, block_full, close;
   logic [SAMPLE_BITS-1:0]     peak_ff, peak_in;
   logic [SAMPLES_W-1:0]       samples_ff, samples_in;
   logic [SQ_W-1:0]            sq_ff;
   logic                       sq_vld_ff;
   logic [SUM_W:0]             sum_add;
   logic [SUM_W-1:0]           sum_next;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic                       last_eos_ff;

   // Division and square root.
   logic [SUM_W-1:0]           div_dq_ff, div_dq_in;
   logic [SAMPLES_W-1:0]       div_den_ff;
   logic [SAMPLES_W-1:0]       div_rem_ff, div_rem_in;
   logic [SAMPLES_W:0]         div_shift, div_diff;
   logic                       div_ge;
   logic [RAD_W-1:0]           rad_ff, rad_in;
   logic [ROOT_W-1:0]          root_ff, root_in;
   logic [ROOT_W:0]            root_rem_ff, root_rem_in;
   logic [ROOT_W+2:0]          root_shift, root_trial, root_diff;
   logic                       root_ge;
   logic [SAMPLE_BITS-1:0]     res_peak_ff;
   logic                       res_last_ff;

   // Result register.
   logic                       out_vld_ff, out_vld_in;
   logic [RESULT_W-1:0]        out_peak_ff, out_rms_ff;
   logic                       out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_frames_ff  <= BLOCK_FRAMES_RESET;
         channel_count_ff <= CHANNEL_COUNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLOCK_FRAMES:  block_frames_ff  <= csr_write_data[BLOCK_FRAMES_W-1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_write_data[CHANNEL_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Out-of-range settings are pulled into the supported range.
   always_comb begin
      bf_wide = BF_CMP_W'(block_frames_ff);
      if (bf_wide < BF_CMP_W'(MIN_BLOCK))      bf_eff = BF_CMP_W'(MIN_BLOCK);
      else if (bf_wide > BF_CMP_W'(MAX_BLOCK)) bf_eff = BF_CMP_W'(MAX_BLOCK);
      else                                     bf_eff = bf_wide;
      frame_limit = bf_eff[FRAMES_W-1:0];

      cc_wide = CC_CMP_W'(channel_count_ff);
      if (cc_wide == '0)                          cc_eff = CC_CMP_W'(1);
      else if (cc_wide > CC_CMP_W'(MAX_CHANNELS)) cc_eff = CC_CMP_W'(MAX_CHANNELS);
      else                                        cc_eff = cc_wide;
   end

   assign accept         = req_chan.valid & cmd.req_ready;
   assign req_chan.ready = cmd.req_ready;

   assign mag = req_chan.sample[SAMPLE_BITS-1] ?
                SAMPLE_BITS'((~req_chan.sample) + 1'b1) : req_chan.sample;

   // Full-width product; the square of a magnitude fits in SQ_W bits.
   assign mag_sq = mag * mag;

   // A frame or block closes at or past its limit, a block also on eos.
   assign chan_last  = (CC_CMP_W'(chan_pos_ff) + CC_CMP_W'(1)) >= cc_eff;
   assign frame_next = frames_ff + 1'b1;
   assign block_full = chan_last && (frame_next >= frame_limit);
   assign close      = block_full | req_chan.end_of_stream;

   // Saturating add of the squared sample taken in the previous cycle.
   assign sum_add  = {1'b0, sum_ff} + (SUM_W + 1)'(sq_ff);
   assign sum_next = !sq_vld_ff ? sum_ff : (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]);

   always_comb begin
      chan_pos_in = chan_pos_ff;
      frames_in   = frames_ff;
      peak_in     = peak_ff;
      samples_in  = samples_ff;
      sum_in      = sum_next;
      if (cmd.fold) begin
         peak_in    = '0;
         samples_in = '0;
         sum_in     = '0;
      end else if (accept) begin
         samples_in = samples_ff + 1'b1;
         if (mag > peak_ff) peak_in = mag;
         if (close) begin
            chan_pos_in = '0;
            frames_in   = '0;
         end else if (chan_last) begin
            chan_pos_in = '0;
            frames_in   = frame_next;
         end else begin
            chan_pos_in = chan_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_pos_ff <= '0;
         frames_ff   <= '0;
         peak_ff     <= '0;
         samples_ff  <= '0;
         sum_ff      <= '0;
         sq_vld_ff   <= 1'b0;
      end else begin
         chan_pos_ff <= chan_pos_in;
         frames_ff   <= frames_in;
         peak_ff     <= peak_in;
         samples_ff  <= samples_in;
         sum_ff      <= sum_in;
         sq_vld_ff   <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sq_ff       <= mag_sq[SQ_W-1:0];
         last_eos_ff <= req_chan.end_of_stream;
      end
   end

   // Restoring division, one quotient bit per step; the dividend shifts
   // out of the top of div_dq while quotient bits enter at the bottom.
   assign div_shift  = {div_rem_ff, div_dq_ff[SUM_W-1]};
   assign div_diff   = div_shift - {1'b0, div_den_ff};
   assign div_ge     = div_shift >= {1'b0, div_den_ff};
   assign div_rem_in = div_ge ? div_diff[SAMPLES_W-1:0] : div_shift[SAMPLES_W-1:0];
   assign div_dq_in  = {div_dq_ff[SUM_W-2:0], div_ge};

   // Digit-by-digit square root, one root bit per step.
   assign root_shift  = {root_rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign root_trial  = {1'b0, root_ff, 2'b01};
   assign root_diff   = root_shift - root_trial;
   assign root_ge     = root_shift >= root_trial;
   assign root_rem_in = root_ge ? root_diff[ROOT_W:0] : root_shift[ROOT_W:0];
   assign root_in     = {root_ff[ROOT_W-2:0], root_ge};
   assign rad_in      = {rad_ff[RAD_W-3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (cmd.fold) begin
         div_dq_ff   <= sum_next;
         div_den_ff  <= samples_ff;
         div_rem_ff  <= '0;
         res_peak_ff <= peak_ff;
         res_last_ff <= last_eos_ff;
      end else if (cmd.div_step) begin
         div_dq_ff  <= div_dq_in;
         div_rem_ff <= div_rem_in;
      end
      if (cmd.root_load) begin
         rad_ff      <= RAD_W'(div_dq_ff[MEAN_W-1:0]);
         root_ff     <= '0;
         root_rem_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff      <= rad_in;
         root_ff     <= root_in;
         root_rem_ff <= root_rem_in;
      end
   end

   assign out_vld_in      = cmd.emit | (out_vld_ff & ~rsp_chan.ready);
   assign status.out_free = ~out_vld_ff | rsp_chan.ready;
   assign status.accept   = accept;
   assign status.close    = close;

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else       out_vld_ff <= out_vld_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_peak_ff <= RESULT_W'(res_peak_ff);
         out_rms_ff  <= RESULT_W'(root_ff);
         out_last_ff <= res_last_ff;
      end
   end

   assign rsp_chan.valid      = out_vld_ff;
   assign rsp_chan.peak       = out_peak_ff;
   assign rsp_chan.rms        = out_rms_ff;
   assign rsp_chan.last_block = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.fold |-> samples_ff != '0)
      else $error("block closed with no samples");

   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> div_rem_ff < div_den_ff)
      else $error("divider remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      cmd.root_step |-> root_rem_ff <= {root_ff, 1'b0})
      else $error("square root remainder out of bound");

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result overwritten before it was taken");
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for block_peak_rms_summarizer: directed table, back pressure, then random streams.
// Depends on bprs_pkg, bprs_sample_if, bprs_summary_if and the block's RTL.
module testbench;
   import bprs_pkg::*;

   // Run timing. Settling covers the longest block close with margin, so no
   // close can still be running when a register is written.
   localparam int CLK_PERIOD       = 10;
   localparam int RESET_CYCLES     = 5;
   localparam int SETTLE_CYCLES    = 100;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int TIMEOUT_CYCLES   = 2_000_000;

   // Stimulus sizing. Random streams continue until both targets are met.
   localparam int BEAT_TARGET     = 1700;
   localparam int SUMMARY_TARGET  = 48;
   localparam int CALM_AFTER      = 1500;
   localparam int EXACT_BLOCK_CAP = 600;
   localparam int PRESSURE_BEATS  = 12;

   typedef logic signed [DEF_SAMPLE_BITS-1:0] sample_type;

   localparam sample_type SAMPLE_MIN = 16'sh8000;
   localparam sample_type SAMPLE_MAX = 16'sh7FFF;

   // Register indexes that map to nothing; writes to them must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 2'd3;

   typedef struct packed {
      logic [RESULT_W-1:0] peak;
      logic [RESULT_W-1:0] rms;
      logic                last_block;
   } summary_type;

   typedef enum logic {ROW_SETTINGS, ROW_BEAT} row_kind_type;

   // One line of the directed table. A settings row carries register values;
   // a beat row carries a sample, and optionally a summary typed in by hand.
   typedef struct packed {
      row_kind_type               kind;
      logic [BLOCK_FRAMES_W-1:0]  frames;
      logic [CHANNEL_COUNT_W-1:0] channels;
      sample_type                 sample;
      logic                       eos;
      logic                       typed;
      summary_type                known;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_write_data;

   bprs_sample_if #(.SAMPLE_BITS(DEF_SAMPLE_BITS)) req_chan ();
   bprs_summary_if                                 rsp_chan ();

   block_peak_rms_summarizer u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan)
   );

   // Shadow copy of the block: register values as written, and the running
   // block accumulators. The sum of squares cannot overflow 46 bits at the
   // default sizes, so it is kept without saturation.
   logic [BLOCK_FRAMES_W-1:0]  frames_reg;
   logic [CHANNEL_COUNT_W-1:0] channels_reg;
   logic [16:0]                peak_acc;
   logic [45:0]                energy_acc;
   logic [12:0]                frame_cnt;
   logic [2:0]                 lane;
   logic [15:0]                sample_cnt;

   summary_type  pending_summaries [$];
   stim_row_type directed_rows [$];
   int           mismatch_count = 0;
   int           beats_sent     = 0;
   int           summaries_due  = 0;
   int           holds_asked    = 0;
   int           holds_served   = 0;
   bit           calm           = 1'b0;

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // Register values as the block applies them: out-of-range values clamp.
   function automatic void effective_limits(output int frame_limit, output int lane_limit);
      if (frames_reg < MIN_BLOCK) frame_limit = MIN_BLOCK;
      else if (frames_reg > DEF_MAX_BLOCK) frame_limit = DEF_MAX_BLOCK;
      else frame_limit = int'(frames_reg);
      if (channels_reg == 0) lane_limit = 1;
      else if (channels_reg > DEF_MAX_CHANNELS) lane_limit = DEF_MAX_CHANNELS;
      else lane_limit = int'(channels_reg);
   endfunction

   // Floor square root, one result bit per step from the top down.
   function automatic logic [16:0] floor_sqrt(input logic [63:0] value);
      logic [16:0] root;
      logic [16:0] trial;
      root = '0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (17'd1 << b);
         if (64'(trial) * 64'(trial) <= value) root = trial;
      end
      return root;
   endfunction

   function automatic void clear_accumulators();
      peak_acc   = '0;
      energy_acc = '0;
      frame_cnt  = '0;
      lane       = '0;
      sample_cnt = '0;
   endfunction

   // Folds one accepted sample into the shadow accumulators. Returns 1 with
   // the block summary when the sample closes a block, by a full frame count
   // or by the end-of-stream flag; the accumulators then clear.
   function automatic bit summarize_sample(input sample_type s, input logic eos,
                                           output summary_type res);
      int          frame_limit;
      int          lane_limit;
      logic [16:0] mag;
      logic [16:0] root;
      bit          full;
      effective_limits(frame_limit, lane_limit);
      mag = s[DEF_SAMPLE_BITS-1] ? 17'h10000 - {1'b0, s} : {1'b0, s};
      if (mag > peak_acc) peak_acc = mag;
      energy_acc = energy_acc + 46'(mag) * 46'(mag);
      sample_cnt = sample_cnt + 1'b1;
      full = 1'b0;
      // A frame closes when the lane reaches or passes the channel count,
      // which matters when the count is lowered in the middle of a frame.
      if (int'(lane) + 1 >= lane_limit) begin
         lane = '0;
         frame_cnt = frame_cnt + 1'b1;
         if (int'(frame_cnt) >= frame_limit) full = 1'b1;
      end else begin
         lane = lane + 1'b1;
      end
      res = '0;
      if (!full && !eos) return 1'b0;
      root = floor_sqrt(64'(energy_acc) / 64'(sample_cnt));
      res.peak       = peak_acc[RESULT_W-1:0];
      res.rms        = root[RESULT_W-1:0];
      res.last_block = eos;
      clear_accumulators();
      return 1'b1;
   endfunction

   function automatic stim_row_type beat_row(input sample_type s, input logic eos);
      stim_row_type row;
      row        = '0;
      row.kind   = ROW_BEAT;
      row.sample = s;
      row.eos    = eos;
      return row;
   endfunction

   // A closing beat whose summary is obvious by hand; always end of stream.
   function automatic stim_row_type known_row(input sample_type s, input int peak,
                                              input int rms);
      stim_row_type row;
      row                  = beat_row(s, 1'b1);
      row.typed            = 1'b1;
      row.known.peak       = RESULT_W'(peak);
      row.known.rms        = RESULT_W'(rms);
      row.known.last_block = 1'b1;
      return row;
   endfunction

   function automatic stim_row_type settings_row(input int frames, input int channels);
      stim_row_type row;
      row          = '0;
      row.kind     = ROW_SETTINGS;
      row.frames   = BLOCK_FRAMES_W'(frames);
      row.channels = CHANNEL_COUNT_W'(channels);
      return row;
   endfunction

   // Mostly full-range random samples, with the two extremes and small
   // amplitudes around zero mixed in.
   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? SAMPLE_MIN : SAMPLE_MAX;
         1: return sample_type'(int'($urandom_range(0, 64)) - 32);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Offers one sample beat and holds it until the block takes it. The
   // expected summary, if any, is queued on the accepting edge. Inputs change
   // only on falling edges; valid is raised again only on a later edge.
   task automatic offer_beat(input sample_type s, input logic eos, input bit typed,
                             input summary_type known);
      summary_type predicted;
      bit          closes;
      @(negedge clock);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.sample        <= s;
      req_chan.end_of_stream <= eos;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      closes = summarize_sample(s, eos, predicted);
      if (typed) pending_summaries.push_back(known);
      else if (closes) pending_summaries.push_back(predicted);
      if (typed || closes) summaries_due++;
      beats_sent++;
   endtask

   // Drops valid, waits for every outstanding summary and then lets the block
   // settle, so that nothing is in flight when registers change.
   task automatic drain_and_settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers back to back, optionally preceded by a write to an
   // unmapped index. The channel count write carries random upper data bits,
   // which the block must drop.
   task automatic apply_settings(input logic [BLOCK_FRAMES_W-1:0] frames,
                                 input logic [CHANNEL_COUNT_W-1:0] channels,
                                 input bit stray);
      logic [CSR_DATA_W-1:0] count_word;
      drain_and_settle();
      count_word = CSR_DATA_W'($urandom);
      count_word[CHANNEL_COUNT_W-1:0] = channels;
      @(negedge clock);
      csr_write_en <= 1'b1;
      if (stray) begin
         csr_index      <= $urandom_range(0, 1) ? CSR_UNMAPPED_HI : CSR_UNMAPPED_LO;
         csr_write_data <= CSR_DATA_W'($urandom);
         @(negedge clock);
      end
      csr_index      <= CSR_BLOCK_FRAMES;
      csr_write_data <= frames;
      @(negedge clock);
      csr_index      <= CSR_CHANNEL_COUNT;
      csr_write_data <= count_word;
      @(negedge clock);
      csr_write_en <= 1'b0;
      frames_reg   = frames;
      channels_reg = channels;
   endtask

   // One random stream. Most are well formed: short streams closed by end of
   // stream, or exactly one block with or without the flag on its last
   // sample. Fragments leave a partial block behind for the next register
   // write, and noisy streams scatter the flag at random.
   task automatic send_stream();
      int   frame_limit;
      int   lane_limit;
      int   block_len;
      int   len;
      int   shape;
      bit   flag_last;
      bit   noisy;
      logic eos;
      effective_limits(frame_limit, lane_limit);
      block_len = frame_limit * lane_limit;
      shape     = $urandom_range(0, 19);
      noisy     = 1'b0;
      if (shape >= 10 && shape < 15 && block_len <= EXACT_BLOCK_CAP) begin
         len       = block_len;
         flag_last = (shape >= 13);
      end else if (shape >= 15 && shape < 17) begin
         len       = $urandom_range(1, 60);
         flag_last = 1'b0;
      end else if (shape >= 17) begin
         len       = $urandom_range(1, 30);
         flag_last = 1'b0;
         noisy     = 1'b1;
      end else begin
         len       = $urandom_range(1, 40);
         flag_last = 1'b1;
      end
      for (int i = 0; i < len; i++) begin
         if (noisy) eos = ($urandom_range(0, 3) == 0);
         else eos = flag_last && (i == len - 1);
         offer_beat(pick_sample(), eos, 1'b0, '0);
      end
   endtask

   function automatic logic [BLOCK_FRAMES_W-1:0] pick_frames();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return BLOCK_FRAMES_W'($urandom_range(1, MIN_BLOCK - 1));
         2: return '1;
         3: return BLOCK_FRAMES_W'(DEF_MAX_BLOCK);
         4: return BLOCK_FRAMES_W'($urandom_range(DEF_MAX_BLOCK + 1, 8191));
         5, 6, 7: return BLOCK_FRAMES_W'($urandom_range(MIN_BLOCK, 200));
         default: return BLOCK_FRAMES_W'($urandom_range(MIN_BLOCK, DEF_MAX_BLOCK));
      endcase
   endfunction

   // Result side. Ready is driven on falling edges: random stalls, one long hold
   // when the stimulus asks for it, and no stalls at all once the run turns calm.
   initial begin : result_sink
      int gap;
      gap = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            gap--;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            gap = LONG_HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(0, 4);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Every summary beat is matched against the oldest expectation.
   always @(posedge clock) begin : summary_check
      summary_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_summaries.size() == 0) begin
            $display("%0t: unexpected summary, expected none, actual peak %0d rms %0d last %0d",
                     $time, rsp_chan.peak, rsp_chan.rms, rsp_chan.last_block);
            mismatch_count++;
         end else begin
            want = pending_summaries.pop_front();
            check_field("peak", want.peak, rsp_chan.peak);
            check_field("rms", want.rms, rsp_chan.rms);
            check_field("last_block", want.last_block, rsp_chan.last_block);
         end
      end
   end

   initial begin : watchdog
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("FAIL block_peak_rms_summarizer");
      $finish;
   end

   initial begin : stimulus
      reset                  = 1'b1;
      csr_write_en           = 1'b0;
      csr_index              = CSR_BLOCK_FRAMES;
      csr_write_data         = '0;
      req_chan.valid         = 1'b0;
      req_chan.sample        = '0;
      req_chan.end_of_stream = 1'b0;
      frames_reg             = BLOCK_FRAMES_RESET;
      channels_reg           = CHANNEL_COUNT_RESET;
      clear_accumulators();

      // Directed table. It starts on the reset settings (512 frames, two
      // channels), so single flagged samples close a partial frame. Rows with
      // a summary typed in are checked against that value directly.
      directed_rows = '{
         known_row(16'sd0, 0, 0),                // empty energy right after reset
         known_row(SAMPLE_MIN, 32768, 32768),    // full-scale negative, magnitude 32768
         known_row(SAMPLE_MAX, 32767, 32767),
         beat_row(-16'sd1, 1'b0),
         known_row(16'sd1, 1, 1),                // flag lands on a frame boundary
         beat_row(16'sd3, 1'b0),
         beat_row(-16'sd4, 1'b0),
         known_row(16'sd5, 5, 4),                // flag in the middle of a frame
         beat_row(16'sd1000, 1'b0),              // leave the block half a frame in
         settings_row(0, 0),                     // clamps to 128 frames, one channel
         beat_row(-16'sd2000, 1'b0),             // lane already past the new count
         beat_row(16'sd7, 1'b1),
         settings_row(8191, 15),                 // clamps to the maximum block and channels
         beat_row(SAMPLE_MAX, 1'b0),
         known_row(SAMPLE_MIN, 32768, 32767),
         settings_row(MIN_BLOCK, 1),
         beat_row(16'sh5555, 1'b1),
         settings_row(DEF_MAX_BLOCK, DEF_MAX_CHANNELS),
         beat_row(16'shAAAA, 1'b1),
         beat_row(16'sd0, 1'b0),
         known_row(16'sd0, 0, 0)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_SETTINGS) begin
            apply_settings(directed_rows[i].frames, directed_rows[i].channels, 1'b0);
         end else begin
            offer_beat(directed_rows[i].sample, directed_rows[i].eos,
                       directed_rows[i].typed, directed_rows[i].known);
         end
      end

      // Back pressure: the result side holds off for a long stretch while
      // every beat closes a block. The first summary parks in the output
      // register, the next close has nowhere to go, and the input stalls.
      apply_settings(BLOCK_FRAMES_W'(MIN_BLOCK), CHANNEL_COUNT_W'(1), 1'b0);
      holds_asked++;
      repeat (PRESSURE_BEATS) offer_beat(pick_sample(), 1'b1, 1'b0, '0);

      // Random phases. Each one drains, picks new settings and sends a few
      // streams; a phase that ends on a fragment leaves a partial block, so
      // the next write lands in the middle of a block. The last stretch of
      // the run has no idling on either side.
      while (beats_sent < BEAT_TARGET || summaries_due < SUMMARY_TARGET) begin
         if (beats_sent >= CALM_AFTER) calm = 1'b1;
         apply_settings(pick_frames(),
                        $urandom_range(0, 3) == 0 ? CHANNEL_COUNT_W'($urandom_range(0, 15))
                                                  : CHANNEL_COUNT_W'($urandom_range(0, 3)),
                        $urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 4)) send_stream();
      end

      drain_and_settle();
      if (mismatch_count == 0) begin
         $display("PASS block_peak_rms_summarizer");
      end else begin
         $display("FAIL block_peak_rms_summarizer");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/bprs_pkg.sv
sv/bprs_sample_if.sv
sv/bprs_summary_if.sv
sv/bprs_ctrl.sv
sv/bprs_datapath.sv
sv/block_peak_rms_summarizer.sv
tb/sv/testbench.sv
